FILE: design/protobuf_varint_field_scanner_core_defines.svh
// Assertion macros shared by the scanner core modules.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PROTOBUF_VARINT_FIELD_SCANNER_CORE_DEFINES_SVH
`define PROTOBUF_VARINT_FIELD_SCANNER_CORE_DEFINES_SVH

// Check that CONS holds in every cycle where ANTE holds.
`define PVFS_ASSERT_IMPLIES(LBL, ANTE, CONS) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
        else $error("pvfs: implication check failed");

// Check that EXPR is never true.
`define PVFS_ASSERT_NEVER(LBL, EXPR) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) !(EXPR)) \
        else $error("pvfs: forbidden condition seen");

`endif

FILE: design/pvfs_pkg.sv
// Shared types and constants for the protobuf varint field scanner.
// No dependencies.
package pvfs_pkg;

    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 29;
    localparam int VALUE_W   = 32;
    localparam int ACC_W     = 64;
    localparam int SHIFT_W   = 7;
    localparam int GROUP_W   = 7;
    localparam int WT_W      = 3;
    localparam int TAGNUM_W  = 32;

    // Shift positions at or above this drop their group.
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(ACC_W);
    localparam logic [SHIFT_W-1:0] GROUP_STEP  = SHIFT_W'(GROUP_W);

    // Wire types handled by the scanner.
    localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [WT_W-1:0] WT_LEN     = 3'd2;
    localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

    localparam logic [ACC_W-1:0] FIXED64_BYTES = 64'd8;
    localparam logic [ACC_W-1:0] FIXED32_BYTES = 64'd4;

    typedef enum logic [6:0] {
        MODE_START = 7'b0000001,
        MODE_TAG   = 7'b0000010,
        MODE_VAL   = 7'b0000100,
        MODE_SKIPV = 7'b0001000,
        MODE_LEN   = 7'b0010000,
        MODE_SKIPN = 7'b0100000,
        MODE_DONE  = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  body_byte;
        logic [FIELD_W-1:0] wanted_field;
        logic               end_of_body;
    } pvfs_item_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] field_value;
        logic               bad_wire_type;
    } pvfs_result_t;

endpackage

FILE: design/protobuf_varint_field_scanner_core.sv
// After its last byte is accepted, a result passes the input and result registers.
// Throughput: one body byte per cycle, bar the stall below; state is registered.
// A last byte waits in the input register only while a previous result is stalled.
// Reset (rst_n, async, active low) clears the scan state and both valid flags;
// there is no clearing pass, the block accepts bytes in the first cycle after reset.
module protobuf_varint_field_scanner_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pvfs_pkg::BYTE_W-1:0]    body_byte,
    input  logic [pvfs_pkg::FIELD_W-1:0]   wanted_field,
    input  logic                           end_of_body,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [pvfs_pkg::VALUE_W-1:0]   field_value,
    output logic                           bad_wire_type
);
    import pvfs_pkg::*;

`include "protobuf_varint_field_scanner_core_defines.svh"

    pvfs_item_t   in_item;
    pvfs_item_t   held_item;
    logic         held_valid;
    logic         step;
    pvfs_result_t dec_result;
    pvfs_result_t res_reg;
    logic         out_valid_reg, out_valid_next;

    assign in_item.body_byte    = body_byte;
    assign in_item.wanted_field = wanted_field;
    assign in_item.end_of_body  = end_of_body;

    // Input register: parts the upstream handshake from the decode logic.
    pvfs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Advance the scan on every held request, except a last byte whose
    // result has nowhere to go because the result register is still stalled.
    assign step = held_valid
                  && (!held_item.end_of_body || !out_valid_reg || !out_stall);

    pvfs_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (held_item),
        .result (dec_result)
    );

    // Result register: load on the last byte, drop once taken downstream.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && held_item.end_of_body)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step && held_item.end_of_body)
            begin
                res_reg <= dec_result;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = res_reg.found;
    assign field_value   = res_reg.field_value;
    assign bad_wire_type = res_reg.bad_wire_type;

    `PVFS_ASSERT_NEVER(a_found_and_bad, res_reg.found && res_reg.bad_wire_type)
    `PVFS_ASSERT_IMPLIES(a_value_needs_hit, !res_reg.found, res_reg.field_value == '0)
    `PVFS_ASSERT_IMPLIES(a_stall_when_held, in_stall, held_valid && out_valid_reg && out_stall)

endmodule

FILE: design/pvfs_in_stage.sv
// Input register for one body byte request and its side fields.
// Depends on pvfs_pkg.
module pvfs_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pvfs_pkg::pvfs_item_t in_item,
    input  logic                take,
    output logic                held_valid,
    output pvfs_pkg::pvfs_item_t held_item
);
    import pvfs_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pvfs_item_t item_reg;
    logic       load;

    // Stall only while a held request is not drained this cycle.
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

FILE: design/pvfs_decoder.sv
// Per-byte scan state machine: tag/length/value varint decode and skipping.
// Depends on pvfs_pkg and the scanner defines header.
`include "protobuf_varint_field_scanner_core_defines.svh"

module pvfs_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  pvfs_pkg::pvfs_item_t  item,
    output pvfs_pkg::pvfs_result_t result
);
    import pvfs_pkg::*;

    scan_mode_t         mode_reg, mode_next, eff_mode;
    logic [ACC_W-1:0]   acc_reg, acc_next, acc_new, grp_ext;
    logic [SHIFT_W-1:0] shift_reg, shift_next, shift_new;
    logic [ACC_W-1:0]   skip_reg, skip_next, skip_dec;
    logic [FIELD_W-1:0] target_reg, target_next;
    logic               hit_reg, hit_next;
    logic               bad_reg, bad_next;
    logic [VALUE_W-1:0] held_reg, held_next;
    logic               more;
    logic               last;
    logic               take_grp;
    logic [WT_W-1:0]    wire_type;
    logic               tag_match;
    logic               acc_idle_mode;

    assign more = item.body_byte[BYTE_W-1];
    assign last = item.end_of_body;

    // Merge the 7-bit group; drop it once the position reaches 64.
    assign take_grp  = shift_reg < SHIFT_LIMIT;
    assign grp_ext   = ACC_W'(item.body_byte[GROUP_W-1:0]);
    assign acc_new   = take_grp ? (acc_reg | (grp_ext << shift_reg[SHIFT_W-2:0])) : acc_reg;
    assign shift_new = take_grp ? (shift_reg + GROUP_STEP) : shift_reg;

    assign wire_type = acc_new[WT_W-1:0];
    assign skip_dec  = skip_reg - ACC_W'(skip_reg != '0);

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        skip_next   = skip_reg;
        target_next = target_reg;
        hit_next    = hit_reg;
        bad_next    = bad_reg;
        held_next   = held_reg;
        eff_mode    = mode_reg;

        // Sample the wanted number on the first byte of a message.
        if (mode_reg == MODE_START)
        begin
            target_next = item.wanted_field;
            eff_mode    = MODE_TAG;
            mode_next   = MODE_TAG;
        end

        tag_match = (acc_new[WT_W +: TAGNUM_W] == TAGNUM_W'(target_next))
                    && (wire_type == WT_VARINT);

        case (eff_mode)
            MODE_TAG:
            begin
                acc_next   = acc_new;
                shift_next = shift_new;
                if (!more || last)
                begin
                    acc_next   = '0;
                    shift_next = '0;
                    if (tag_match)
                    begin
                        if (last)
                        begin
                            hit_next  = 1'b1;
                            held_next = '0;
                            mode_next = MODE_DONE;
                        end
                        else
                        begin
                            mode_next = MODE_VAL;
                        end
                    end
                    else
                    begin
                        case (wire_type)
                            WT_VARINT:
                            begin
                                mode_next = MODE_SKIPV;
                            end
                            WT_LEN:
                            begin
                                mode_next = MODE_LEN;
                            end
                            WT_FIXED64:
                            begin
                                skip_next = FIXED64_BYTES;
                                mode_next = MODE_SKIPN;
                            end
                            WT_FIXED32:
                            begin
                                skip_next = FIXED32_BYTES;
                                mode_next = MODE_SKIPN;
                            end
                            default:
                            begin
                                bad_next  = 1'b1;
                                mode_next = MODE_DONE;
                            end
                        endcase
                    end
                end
            end
            MODE_VAL:
            begin
                acc_next   = acc_new;
                shift_next = shift_new;
                if (!more || last)
                begin
                    hit_next   = 1'b1;
                    held_next  = acc_new[VALUE_W-1:0];
                    acc_next   = '0;
                    shift_next = '0;
                    mode_next  = MODE_DONE;
                end
            end
            MODE_SKIPV:
            begin
                if (!more)
                begin
                    mode_next = MODE_TAG;
                end
            end
            MODE_LEN:
            begin
                acc_next   = acc_new;
                shift_next = shift_new;
                if (!more)
                begin
                    skip_next  = acc_new;
                    acc_next   = '0;
                    shift_next = '0;
                    mode_next  = (acc_new != '0) ? MODE_SKIPN : MODE_TAG;
                end
            end
            MODE_SKIPN:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    mode_next = MODE_TAG;
                end
            end
            default:
            begin
                // Stopped: ignore bytes until the end of the message.
            end
        endcase
    end

    // Result as seen after this byte; only meaningful on the last byte.
    assign result.found         = hit_next;
    assign result.field_value   = hit_next ? held_next : '0;
    assign result.bad_wire_type = bad_next;

    // Modes that never hold a partial varint.
    assign acc_idle_mode = (mode_reg == MODE_SKIPV) || (mode_reg == MODE_SKIPN)
                           || (mode_reg == MODE_DONE) || (mode_reg == MODE_START);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            acc_reg    <= '0;
            shift_reg  <= '0;
            skip_reg   <= '0;
            target_reg <= '0;
            hit_reg    <= 1'b0;
            bad_reg    <= 1'b0;
            held_reg   <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                mode_reg   <= MODE_START;
                acc_reg    <= '0;
                shift_reg  <= '0;
                skip_reg   <= '0;
                target_reg <= '0;
                hit_reg    <= 1'b0;
                bad_reg    <= 1'b0;
                held_reg   <= '0;
            end
            else
            begin
                mode_reg   <= mode_next;
                acc_reg    <= acc_next;
                shift_reg  <= shift_next;
                skip_reg   <= skip_next;
                target_reg <= target_next;
                hit_reg    <= hit_next;
                bad_reg    <= bad_next;
                held_reg   <= held_next;
            end
        end
    end

    `PVFS_ASSERT_IMPLIES(a_skip_idle, mode_reg != MODE_SKIPN, skip_reg == '0)
    `PVFS_ASSERT_IMPLIES(a_acc_clear, acc_idle_mode, (acc_reg == '0) && (shift_reg == '0))
    `PVFS_ASSERT_IMPLIES(a_flag_done, hit_reg || bad_reg, mode_reg == MODE_DONE)

endmodule

FILE: tb/protobuf_varint_field_scanner_core_tb.sv
// Self-checking bench for protobuf_varint_field_scanner_core: feeds message bodies byte by byte,
// predicts every end-of-body result and compares it field by field with what the core returns.
// Depends on pvfs_pkg and the scanner core RTL only.
module protobuf_varint_field_scanner_core_tb;
    import pvfs_pkg::*;

    // Stimulus volume, pressure points and run limits.
    localparam int TARGET_BYTES    = 1900;
    localparam int IDLE_LIMIT      = 3000;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AT_RESULT  = 90;
    localparam int DRAIN_EVERY     = 45;
    localparam int DRAIN_PHASE     = 20;
    localparam int SETTLE_CYCLES   = 10;
    localparam int MAX_GAP         = 4;

    // Wire types the core refuses; any of them ends the scan.
    localparam logic [WT_W-1:0] WT_GROUP_START = 3'd3;
    localparam logic [WT_W-1:0] WT_GROUP_END   = 3'd4;
    localparam logic [WT_W-1:0] WT_RESERVED_6  = 3'd6;
    localparam logic [WT_W-1:0] WT_RESERVED_7  = 3'd7;

    // One request on the input channel plus how the sender paces it.
    typedef struct {
        pvfs_item_t  item;
        int unsigned gap;
        bit          drain;
    } body_request_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    body_byte     = '0;
    logic [FIELD_W-1:0]   wanted_field  = '0;
    logic                 end_of_body   = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 found;
    logic [VALUE_W-1:0]   field_value;
    logic                 bad_wire_type;

    body_request_t        pending_body_bytes[$];
    pvfs_result_t         expected_field_results[$];
    logic [BYTE_W-1:0]    msg_bytes[$];

    pvfs_item_t           driven_item;
    int unsigned          gap_count;
    int unsigned          stall_left;
    int unsigned          results_seen;
    int unsigned          idle_cycles;
    int unsigned          message_count;
    bit                   failed;

    // Predicted scanner state.
    scan_mode_t           scan_state;
    logic [ACC_W-1:0]     acc;
    logic [SHIFT_W-1:0]   group_pos;
    logic [ACC_W-1:0]     bytes_to_skip;
    logic [FIELD_W-1:0]   sampled_field;
    bit                   hit_seen;
    bit                   bad_seen;
    logic [VALUE_W-1:0]   hit_value;

    protobuf_varint_field_scanner_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .body_byte     (body_byte),
        .wanted_field  (wanted_field),
        .end_of_body   (end_of_body),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .field_value   (field_value),
        .bad_wire_type (bad_wire_type)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------

    // Return to the idle state that precedes the first byte of a message.
    function automatic void clear_scan();
        scan_state    = MODE_START;
        acc           = '0;
        group_pos     = '0;
        bytes_to_skip = '0;
        sampled_field = '0;
        hit_seen      = 1'b0;
        bad_seen      = 1'b0;
        hit_value     = '0;
    endfunction

    // Fold one 7-bit group into the varint; drop groups past bit 63.
    function automatic void add_group(logic [BYTE_W-1:0] b);
        if (group_pos < SHIFT_LIMIT)
        begin
            acc       |= ACC_W'(b[GROUP_W-1:0]) << group_pos;
            group_pos += GROUP_STEP;
        end
    endfunction

    // Judge a complete (or cut-off) tag: match, skip, or stop on a bad wire type.
    function automatic void finish_tag(bit last);
        logic [TAGNUM_W-1:0] tag_field;
        logic [WT_W-1:0]     wt;
        tag_field = acc[TAGNUM_W+WT_W-1:WT_W];
        wt        = acc[WT_W-1:0];
        acc       = '0;
        group_pos = '0;
        if (tag_field == TAGNUM_W'(sampled_field) && wt == WT_VARINT)
        begin
            // A matching tag on the last byte has an empty value.
            if (last)
            begin
                hit_seen   = 1'b1;
                hit_value  = '0;
                scan_state = MODE_DONE;
            end
            else
            begin
                scan_state = MODE_VAL;
            end
        end
        else
        begin
            case (wt)
                WT_VARINT:
                begin
                    scan_state = MODE_SKIPV;
                end
                WT_LEN:
                begin
                    scan_state = MODE_LEN;
                end
                WT_FIXED64:
                begin
                    bytes_to_skip = FIXED64_BYTES;
                    scan_state    = MODE_SKIPN;
                end
                WT_FIXED32:
                begin
                    bytes_to_skip = FIXED32_BYTES;
                    scan_state    = MODE_SKIPN;
                end
                default:
                begin
                    bad_seen   = 1'b1;
                    scan_state = MODE_DONE;
                end
            endcase
        end
    endfunction

    // Advance the scan by one accepted byte; return 1 with the result on an end-of-body byte.
    function automatic bit predict_scan_byte(pvfs_item_t it, output pvfs_result_t res);
        bit more;
        more = it.body_byte[BYTE_W-1];
        res  = '0;
        if (scan_state == MODE_START)
        begin
            sampled_field = it.wanted_field;
            scan_state    = MODE_TAG;
        end
        case (scan_state)
            MODE_TAG:
            begin
                add_group(it.body_byte);
                if (!more || it.end_of_body)
                    finish_tag(it.end_of_body);
            end
            MODE_VAL:
            begin
                add_group(it.body_byte);
                if (!more || it.end_of_body)
                begin
                    hit_seen   = 1'b1;
                    hit_value  = acc[VALUE_W-1:0];
                    acc        = '0;
                    group_pos  = '0;
                    scan_state = MODE_DONE;
                end
            end
            MODE_SKIPV:
            begin
                if (!more)
                    scan_state = MODE_TAG;
            end
            MODE_LEN:
            begin
                add_group(it.body_byte);
                if (!more)
                begin
                    bytes_to_skip = acc;
                    acc           = '0;
                    group_pos     = '0;
                    scan_state    = (bytes_to_skip != 0) ? MODE_SKIPN : MODE_TAG;
                end
            end
            MODE_SKIPN:
            begin
                if (bytes_to_skip != 0)
                    bytes_to_skip = bytes_to_skip - 1;
                if (bytes_to_skip == 0)
                    scan_state = MODE_TAG;
            end
            default:
            begin
            end
        endcase
        if (!it.end_of_body)
            return 1'b0;
        res.found         = hit_seen;
        res.field_value   = hit_seen ? hit_value : '0;
        res.bad_wire_type = bad_seen;
        clear_scan();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Message construction
    // ------------------------------------------------------------------

    // Add one byte at the tail of the message under construction.
    function automatic void append_byte(logic [BYTE_W-1:0] b);
        msg_bytes = {msg_bytes, b};
    endfunction

    // Append v as a minimal varint.
    task automatic add_varint(logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] rest;
        rest = v;
        while (rest >= 128)
        begin
            append_byte({1'b1, rest[GROUP_W-1:0]});
            rest = rest >> GROUP_W;
        end
        append_byte(rest[BYTE_W-1:0]);
    endtask

    // Append an overlong varint whose upper groups fall past bit 63.
    task automatic add_long_varint();
        int unsigned n;
        n = $urandom_range(11, 13);
        for (int unsigned i = 0; i < n; i++)
            append_byte({i != n - 1, 7'($urandom)});
    endtask

    // Random 64-bit value of random significant length, zero included.
    function automatic logic [ACC_W-1:0] random_value();
        logic [ACC_W-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(0, ACC_W);
    endfunction

    // Mostly small field numbers, some full-width, some with bits above the 32-bit cut.
    function automatic logic [ACC_W-1:0] random_field_number();
        case ($urandom_range(0, 9))
            0, 1:    return ACC_W'(29'($urandom));
            2:       return {3'b000, 29'($urandom), 3'b000, 29'($urandom)};
            default: return ACC_W'($urandom_range(0, 20));
        endcase
    endfunction

    // Build a 1-5 field body, maybe malformed; pick the wanted number, usually a varint field.
    task automatic build_message(output logic [FIELD_W-1:0] want);
        int unsigned      n_fields;
        int unsigned      pick;
        int unsigned      len;
        logic [ACC_W-1:0] fnum;
        logic [WT_W-1:0]  wt;
        logic [ACC_W-1:0] varint_fields[$];
        bit               stop;
        msg_bytes.delete();
        n_fields = $urandom_range(1, 5);
        stop     = 1'b0;
        for (int unsigned i = 0; i < n_fields && !stop; i++)
        begin
            fnum = random_field_number();
            pick = $urandom_range(0, 19);
            if (pick < 8)
                wt = WT_VARINT;
            else if (pick < 13)
                wt = WT_LEN;
            else if (pick < 15)
                wt = WT_FIXED64;
            else if (pick < 17)
                wt = WT_FIXED32;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       wt = WT_GROUP_START;
                    1:       wt = WT_GROUP_END;
                    2:       wt = WT_RESERVED_6;
                    default: wt = WT_RESERVED_7;
                endcase
            end
            add_varint((fnum << WT_W) | ACC_W'(wt));
            case (wt)
                WT_VARINT:
                begin
                    varint_fields = {varint_fields, fnum};
                    if ($urandom_range(0, 9) == 0)
                        add_long_varint();
                    else
                        add_varint(random_value());
                end
                WT_LEN:
                begin
                    // Now and then claim a length far past the end of the body.
                    if ($urandom_range(0, 29) == 0)
                    begin
                        add_varint(random_value() | ACC_W'(256));
                        stop = 1'b1;
                    end
                    else
                    begin
                        len = $urandom_range(0, 5);
                        add_varint(ACC_W'(len));
                        repeat (len) append_byte(8'($urandom));
                    end
                end
                WT_FIXED64:
                begin
                    repeat (8) append_byte(8'($urandom));
                end
                WT_FIXED32:
                begin
                    repeat (4) append_byte(8'($urandom));
                end
                default:
                begin
                    // Bytes after a refused wire type are ignored by the core.
                    repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
                    stop = 1'b1;
                end
            endcase
        end
        if (varint_fields.size() != 0 && $urandom_range(0, 3) != 0)
            want = varint_fields[$urandom_range(0, varint_fields.size() - 1)][FIELD_W-1:0];
        else if ($urandom_range(0, 1) == 0)
            want = 29'($urandom);
        else
            want = FIELD_W'($urandom_range(0, 20));
    endtask

    // Turn msg_bytes into requests; wanted_field only matters on the first byte.
    task automatic queue_message(logic [FIELD_W-1:0] want);
        body_request_t req;
        bit            quiet;
        quiet = (message_count % 12) < 3;
        foreach (msg_bytes[i])
        begin
            req.item.body_byte    = msg_bytes[i];
            req.item.wanted_field = (i == 0) ? want : 29'($urandom);
            req.item.end_of_body  = (i == msg_bytes.size() - 1);
            req.gap               = quiet ? 0 : $urandom_range(0, MAX_GAP);
            req.drain             = (i == 0) && (message_count % DRAIN_EVERY == DRAIN_PHASE);
            pending_body_bytes    = {pending_body_bytes, req};
        end
        message_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer one request at a time, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pvfs_result_t  predicted;
        body_request_t next_req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            // Predict on the request the core takes at this edge.
            if (in_valid && !in_stall)
            begin
                if (predict_scan_byte(driven_item, predicted))
                    expected_field_results = {expected_field_results, predicted};
            end
            // Hold a stalled request; otherwise pick the next one or idle.
            if (!in_valid || !in_stall)
            begin
                if (pending_body_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_body_bytes[0].drain && expected_field_results.size() != 0)
                begin
                    // Pause until every outstanding result has come back.
                    in_valid <= 1'b0;
                end
                else if (gap_count < pending_body_bytes[0].gap)
                begin
                    gap_count++;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_req     = pending_body_bytes[0];
                    pending_body_bytes.delete(0);
                    gap_count    = 0;
                    driven_item  = next_req.item;
                    in_valid     <= 1'b1;
                    body_byte    <= next_req.item.body_byte;
                    wanted_field <= next_req.item.wanted_field;
                    end_of_body  <= next_req.item.end_of_body;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result, then draw the next stall
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pvfs_result_t oldest;
        int unsigned  hold;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            hold = stall_left;
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_field_results.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0b field_value=%08h bad_wire_type=%0b",
                             $time, found, field_value, bad_wire_type);
                    failed = 1'b1;
                end
                else
                begin
                    oldest = expected_field_results[0];
                    expected_field_results.delete(0);
                    if (found !== oldest.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, oldest.found, found);
                        failed = 1'b1;
                    end
                    if (field_value !== oldest.field_value)
                    begin
                        $display("%0t: field_value mismatch: expected %08h, actual %08h",
                                 $time, oldest.field_value, field_value);
                        failed = 1'b1;
                    end
                    if (bad_wire_type !== oldest.bad_wire_type)
                    begin
                        $display("%0t: bad_wire_type mismatch: expected %0b, actual %0b",
                                 $time, oldest.bad_wire_type, bad_wire_type);
                        failed = 1'b1;
                    end
                end
                // One long hold-off to back the core up; quiet stretches with no stall.
                if (results_seen == HOLD_AT_RESULT)
                    hold = LONG_HOLD;
                else if (results_seen % 50 < 10)
                    hold = 0;
                else
                    hold = $urandom_range(0, MAX_GAP);
            end
            if (hold > 0)
            begin
                out_stall  <= 1'b1;
                stall_left = hold - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left = 0;
            end
        end
    end

    // Abort when neither channel moves a request for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [FIELD_W-1:0] want;
        int unsigned        random_bytes;
        int unsigned        cut;
        int unsigned        kind;
        clear_scan();
        failed        = 1'b0;
        results_seen  = 0;
        idle_cycles   = 0;
        message_count = 0;
        random_bytes  = 0;

        // Field 1 varint tag alone on the last byte: hit with an empty value.
        msg_bytes = '{8'h08};
        queue_message(29'd1);
        // Field 1 = 150.
        msg_bytes = '{8'h08, 8'h96, 8'h01};
        queue_message(29'd1);
        // Skip field 1, hit field 2.
        msg_bytes = '{8'h08, 8'h05, 8'h10, 8'h07};
        queue_message(29'd2);
        // Start-group wire type stops the scan; the trailing byte is ignored.
        msg_bytes = '{8'h0B, 8'h00};
        queue_message(29'd1);
        // Zero-length field skipped at once, then field 1 = 42.
        msg_bytes = '{8'h12, 8'h00, 8'h08, 8'h2A};
        queue_message(29'd1);
        // Fixed32 field running past the end.
        msg_bytes = '{8'h0D, 8'h01};
        queue_message(29'd1);
        // Tag cut off by the end, judged as complete: matches field 1.
        msg_bytes = '{8'h88};
        queue_message(29'd1);
        // Value cut off by the end: partial value reported.
        msg_bytes = '{8'h08, 8'hFF, 8'hFF};
        queue_message(29'd1);
        // Largest field number with a one-byte value.
        msg_bytes.delete();
        add_varint(ACC_W'({29'h1FFF_FFFF, WT_VARINT}));
        append_byte(8'h7F);
        queue_message(29'h1FFF_FFFF);

        // Random part: mostly well-formed bodies, some cut short, some plain noise.
        while (random_bytes < TARGET_BYTES)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 14)
            begin
                build_message(want);
            end
            else if (kind < 17)
            begin
                build_message(want);
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut)
                    msg_bytes.delete(msg_bytes.size() - 1);
            end
            else
            begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
                want = ($urandom_range(0, 1) == 0) ? 29'($urandom)
                                                   : FIELD_W'($urandom_range(0, 20));
            end
            random_bytes += msg_bytes.size();
            queue_message(want);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests taken, all results back, then let the pipeline settle.
        while (pending_body_bytes.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_field_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failed)
            $display("Regression FAIL");
        else
            $display("Regression PASS");
        $finish;
    end

endmodule
